// ----- rtl/core/tdc_hwd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDC hit word decoder package
// Shared constants, codes and record types of the decoder.
// ----------------------------------------------------------------------------
package tdc_hwd_pkg;

  // Channels with hit slots and slots per channel and group.
  localparam int unsigned CHANNELS = 8;
  localparam int unsigned HITS     = 10;

  // Field widths.
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CHAN_W    = 6;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned VALUE_W   = 24;
  localparam int unsigned PART_W    = 24;
  localparam int unsigned STAMP_W   = 2 * PART_W;
  localparam int unsigned ABS_W     = 64;
  localparam int unsigned CNT_W     = $clog2(HITS + 1);
  localparam int unsigned CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Depth of the queue between the parts and of the result queue; a power of two so the pointers wrap.
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // Word decode constants.
  localparam logic [WORD_W-1:0] TYPE_MASK     = 32'hC000_0000;
  localparam logic [WORD_W-1:0] TYPE_LOW_HIT  = 32'h4000_0000;
  localparam logic [7:0]        ROLLOVER_TAG  = 8'h10;
  localparam logic [3:0]        GROUP_TAG     = 4'h0;

  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [QPTR_W-1:0]   qptr_t;
  typedef logic [QCNT_W-1:0]   qcnt_t;
  typedef logic [CH_IDX_W-1:0] ch_idx_t;

  typedef enum logic [2:0] {
    KIND_HIT_STORED  = 3'd0,
    KIND_HIT_DROPPED = 3'd1,
    KIND_CHAN_RANGE  = 3'd2,
    KIND_ROLLOVER    = 3'd3,
    KIND_GROUP       = 3'd4,
    KIND_IGNORED     = 3'd5
  } word_kind_e;

  typedef enum logic [2:0] {
    CLS_HIT    = 3'd0,
    CLS_RANGE  = 3'd1,
    CLS_ROLL   = 3'd2,
    CLS_GROUP  = 3'd3,
    CLS_IGNORE = 3'd4
  } cmd_class_e;

  // Classified word, front to back.
  typedef struct packed {
    cmd_class_e          cls;
    logic [CHAN_W-1:0]   channel;
    logic [VALUE_W-1:0]  data;
    logic                last;
    logic                restart;
  } cmd_t;

  // Result record held in the output queue.
  typedef struct packed {
    word_kind_e          kind;
    logic [CHAN_W-1:0]   channel;
    logic [SLOT_W-1:0]   slot;
    logic [VALUE_W-1:0]  value;
    logic                done;
    logic                ok;
    logic [ABS_W-1:0]    timestamp;
  } result_t;

endpackage

// ----- rtl/core/tdc_hwd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDC hit word decoder front
// Classifies incoming words and queues them for the back part.
// ----------------------------------------------------------------------------
module tdc_hwd_front (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      push,
  output logic                                      full,
  input  logic [tdc_hwd_pkg::WORD_W-1:0]            data_word_i,
  input  logic                                      last_word_i,
  input  logic                                      restart_i,
  output logic                                      cmd_valid_o,
  input  logic                                      cmd_pop_i,
  output tdc_hwd_pkg::cmd_t                         cmd_o
);

  tdc_hwd_pkg::cmd_t  cmd_mem_q [tdc_hwd_pkg::QDEPTH];
  tdc_hwd_pkg::cmd_t  cmd_new;
  tdc_hwd_pkg::qptr_t wr_ptr_q, rd_ptr_q;
  tdc_hwd_pkg::qcnt_t cnt_q;
  logic               wr_en, rd_en;

  // Classify the word.
  always_comb begin
    cmd_new.channel = data_word_i[tdc_hwd_pkg::VALUE_W +: tdc_hwd_pkg::CHAN_W];
    cmd_new.data    = data_word_i[tdc_hwd_pkg::VALUE_W-1:0];
    cmd_new.last    = last_word_i;
    cmd_new.restart = restart_i;
    if ((data_word_i & tdc_hwd_pkg::TYPE_MASK) > tdc_hwd_pkg::TYPE_LOW_HIT) begin
      if (int'(cmd_new.channel) < int'(tdc_hwd_pkg::CHANNELS)) begin
        cmd_new.cls = tdc_hwd_pkg::CLS_HIT;
      end else begin
        cmd_new.cls = tdc_hwd_pkg::CLS_RANGE;
      end
    end else if (data_word_i[31:24] == tdc_hwd_pkg::ROLLOVER_TAG) begin
      cmd_new.cls = tdc_hwd_pkg::CLS_ROLL;
    end else if (data_word_i[31:28] == tdc_hwd_pkg::GROUP_TAG) begin
      cmd_new.cls = tdc_hwd_pkg::CLS_GROUP;
    end else begin
      cmd_new.cls = tdc_hwd_pkg::CLS_IGNORE;
    end
  end

  assign full        = (cnt_q == tdc_hwd_pkg::qcnt_t'(tdc_hwd_pkg::QDEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = cmd_mem_q[rd_ptr_q];
  assign wr_en       = push && !full;
  assign rd_en       = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + tdc_hwd_pkg::qptr_t'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + tdc_hwd_pkg::qptr_t'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + tdc_hwd_pkg::qcnt_t'(1);
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - tdc_hwd_pkg::qcnt_t'(1);
      end
    end
  end

  // Queue storage carries no reset.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cmd_mem_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ----- rtl/core/tdc_hwd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDC hit word decoder back
// Applies classified words to slot counters and stamps, queues the results.
// ----------------------------------------------------------------------------
module tdc_hwd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_pop_o,
  input  tdc_hwd_pkg::cmd_t     cmd_i,
  output logic                  empty,
  input  logic                  pop,
  output tdc_hwd_pkg::result_t  res_o
);

  // Per-group and stamp state.
  tdc_hwd_pkg::cnt_t                    cnt_q [tdc_hwd_pkg::CHANNELS];
  logic                                 start_q;
  logic                                 any_q;
  logic [tdc_hwd_pkg::PART_W-1:0]       roll_q, grp_q;
  logic [tdc_hwd_pkg::STAMP_W-1:0]      prev_q;
  logic [tdc_hwd_pkg::ABS_W-1:0]        abs_q;

  // Result queue.
  tdc_hwd_pkg::result_t res_mem_q [tdc_hwd_pkg::QDEPTH];
  tdc_hwd_pkg::qptr_t   wr_ptr_q, rd_ptr_q;
  tdc_hwd_pkg::qcnt_t   res_cnt_q;
  logic                 res_full, fire, rd_en;

  tdc_hwd_pkg::ch_idx_t                 idx;
  tdc_hwd_pkg::cnt_t                    cnt_rd;
  logic                                 store;
  logic [tdc_hwd_pkg::PART_W-1:0]       roll_new, grp_new;
  logic [tdc_hwd_pkg::STAMP_W-1:0]      prev_cur, stamp, delta;
  logic [tdc_hwd_pkg::ABS_W-1:0]        abs_cur, abs_new;
  logic                                 any_new;
  tdc_hwd_pkg::result_t                 res_new;

  assign res_full  = (res_cnt_q == tdc_hwd_pkg::qcnt_t'(tdc_hwd_pkg::QDEPTH));
  assign fire      = cmd_valid_i && !res_full;
  assign cmd_pop_o = fire;
  assign empty     = (res_cnt_q == '0);
  assign rd_en     = pop && !empty;
  assign res_o     = res_mem_q[rd_ptr_q];

  assign idx    = cmd_i.channel[tdc_hwd_pkg::CH_IDX_W-1:0];
  // A group start reads every counter as zero.
  assign cnt_rd = start_q ? '0 : cnt_q[idx];
  assign store  = (cmd_i.cls == tdc_hwd_pkg::CLS_HIT)
               && (cnt_rd < tdc_hwd_pkg::cnt_t'(tdc_hwd_pkg::HITS));

  always_comb begin
    roll_new = cmd_i.restart ? '0 : roll_q;
    grp_new  = cmd_i.restart ? '0 : grp_q;
    prev_cur = cmd_i.restart ? '0 : prev_q;
    abs_cur  = cmd_i.restart ? '0 : abs_q;
    if (cmd_i.cls == tdc_hwd_pkg::CLS_ROLL) begin
      roll_new = cmd_i.data;
    end
    if (cmd_i.cls == tdc_hwd_pkg::CLS_GROUP) begin
      grp_new = cmd_i.data;
    end
    stamp   = {roll_new, grp_new};
    // A backward step gains 2^48 through the modulo-2^48 difference.
    delta   = stamp - prev_cur;
    abs_new = abs_cur + {{(tdc_hwd_pkg::ABS_W - tdc_hwd_pkg::STAMP_W){1'b0}}, delta};
    any_new = (!start_q && any_q) || store;
  end

  always_comb begin
    res_new.channel   = '0;
    res_new.slot      = '0;
    res_new.value     = '0;
    res_new.done      = cmd_i.last;
    res_new.ok        = cmd_i.last && any_new;
    res_new.timestamp = cmd_i.last ? abs_new : '0;
    case (cmd_i.cls)
      tdc_hwd_pkg::CLS_HIT: begin
        res_new.channel = cmd_i.channel;
        res_new.value   = cmd_i.data;
        if (store) begin
          res_new.kind = tdc_hwd_pkg::KIND_HIT_STORED;
          res_new.slot = tdc_hwd_pkg::SLOT_W'(cnt_rd);
        end else begin
          res_new.kind = tdc_hwd_pkg::KIND_HIT_DROPPED;
        end
      end
      tdc_hwd_pkg::CLS_RANGE: begin
        res_new.kind    = tdc_hwd_pkg::KIND_CHAN_RANGE;
        res_new.channel = cmd_i.channel;
        res_new.value   = cmd_i.data;
      end
      tdc_hwd_pkg::CLS_ROLL:  res_new.kind = tdc_hwd_pkg::KIND_ROLLOVER;
      tdc_hwd_pkg::CLS_GROUP: res_new.kind = tdc_hwd_pkg::KIND_GROUP;
      default:                res_new.kind = tdc_hwd_pkg::KIND_IGNORED;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(tdc_hwd_pkg::CHANNELS); i++) begin
        cnt_q[i] <= '0;
      end
      start_q   <= 1'b1;
      any_q     <= 1'b0;
      roll_q    <= '0;
      grp_q     <= '0;
      prev_q    <= '0;
      abs_q     <= '0;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      res_cnt_q <= '0;
    end else begin
      if (fire) begin
        for (int i = 0; i < int'(tdc_hwd_pkg::CHANNELS); i++) begin
          if (store && (idx == tdc_hwd_pkg::ch_idx_t'(i))) begin
            cnt_q[i] <= cnt_rd + tdc_hwd_pkg::cnt_t'(1);
          end else if (start_q) begin
            // Clear the counters on the first word of a group.
            cnt_q[i] <= '0;
          end
        end
        any_q   <= any_new;
        start_q <= cmd_i.last;
        roll_q  <= roll_new;
        grp_q   <= grp_new;
        if (cmd_i.last) begin
          prev_q <= stamp;
          abs_q  <= abs_new;
        end else begin
          prev_q <= prev_cur;
          abs_q  <= abs_cur;
        end
        wr_ptr_q <= wr_ptr_q + tdc_hwd_pkg::qptr_t'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + tdc_hwd_pkg::qptr_t'(1);
      end
      if (fire && !rd_en) begin
        res_cnt_q <= res_cnt_q + tdc_hwd_pkg::qcnt_t'(1);
      end else if (rd_en && !fire) begin
        res_cnt_q <= res_cnt_q - tdc_hwd_pkg::qcnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_mem_q[wr_ptr_q] <= res_new;
    end
  end

endmodule

// ----- rtl/core/tdc_hit_word_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDC hit word decoder
// Decodes converter words into hit, rollover and group records with stamps.
// ----------------------------------------------------------------------------
// Push one 32-bit converter word per transfer and pop exactly one result per
// word, in order. The decoder sustains one word per clock while results are
// popped: a front part classifies each word on entry into a two-entry queue,
// and a back part updates the per-channel slot counters and the 64-bit
// absolute stamp for each word, writing into a two-entry result queue. A
// word waits in the front queue and its result in the result queue before
// it shows on the output ports; a full result queue holds words back in the
// front queue. Either side may stall freely; full rises only when both
// queues have backed up. The absolute stamp update is one 48-bit subtract
// followed by a 64-bit add, which sets the critical path of the back part.
// ----------------------------------------------------------------------------
module tdc_hit_word_decoder (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Word input, queue style
  input  logic                                   push,
  output logic                                   full,
  input  logic [tdc_hwd_pkg::WORD_W-1:0]         data_word_i,
  input  logic                                   last_word_i,
  input  logic                                   restart_i,
  // Result output, queue style
  output logic                                   empty,
  input  logic                                   pop,
  output logic [2:0]                             word_kind_o,
  output logic [tdc_hwd_pkg::CHAN_W-1:0]         channel_o,
  output logic [tdc_hwd_pkg::SLOT_W-1:0]         hit_slot_o,
  output logic signed [tdc_hwd_pkg::VALUE_W-1:0] hit_value_o,
  output logic                                   group_done_o,
  output logic                                   group_ok_o,
  output logic [tdc_hwd_pkg::ABS_W-1:0]          timestamp_o
);

  logic                 cmd_valid;
  logic                 cmd_pop;
  tdc_hwd_pkg::cmd_t    cmd;
  tdc_hwd_pkg::result_t res;

  // Classify and hold incoming words.
  tdc_hwd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_word_i (data_word_i),
    .last_word_i (last_word_i),
    .restart_i   (restart_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  // Advance counters and stamps, queue one result per word.
  tdc_hwd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res)
  );

  assign word_kind_o  = res.kind;
  assign channel_o    = res.channel;
  assign hit_slot_o   = res.slot;
  assign hit_value_o  = res.value;
  assign group_done_o = res.done;
  assign group_ok_o   = res.ok;
  assign timestamp_o  = res.timestamp;

endmodule

// ----- tb/tdc_hit_word_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDC hit word decoder testbench
// Streams directed and random converter word groups into the decoder with
// random gaps on both queue sides, predicts every result record in step with
// the accepted words and checks each popped record field by field.
// ----------------------------------------------------------------------------
module tdc_hit_word_decoder_tb;

  import tdc_hwd_pkg::*;

  // One converter word with its group flags.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
    logic              restart;
  } word_item_t;

  localparam int unsigned WORD_TARGET = 1725;

  logic                       clk_i        = 1'b0;
  logic                       rst_ni       = 1'b0;
  logic                       push         = 1'b0;
  logic                       full;
  logic [WORD_W-1:0]          data_word_i  = '0;
  logic                       last_word_i  = 1'b0;
  logic                       restart_i    = 1'b0;
  logic                       empty;
  logic                       pop          = 1'b0;
  logic [2:0]                 word_kind_o;
  logic [CHAN_W-1:0]          channel_o;
  logic [SLOT_W-1:0]          hit_slot_o;
  logic signed [VALUE_W-1:0]  hit_value_o;
  logic                       group_done_o;
  logic                       group_ok_o;
  logic [ABS_W-1:0]           timestamp_o;

  tdc_hit_word_decoder DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .data_word_i  (data_word_i),
    .last_word_i  (last_word_i),
    .restart_i    (restart_i),
    .empty        (empty),
    .pop          (pop),
    .word_kind_o  (word_kind_o),
    .channel_o    (channel_o),
    .hit_slot_o   (hit_slot_o),
    .hit_value_o  (hit_value_o),
    .group_done_o (group_done_o),
    .group_ok_o   (group_ok_o),
    .timestamp_o  (timestamp_o)
  );

  // Words still to be sent, and decoded records still to be popped.
  word_item_t word_q[$];
  result_t    decoded_q[$];

  // Shadow decoder state.
  logic [SLOT_W-1:0]  slot_count [CHANNELS];
  logic [PART_W-1:0]  roll_part  = '0;
  logic [PART_W-1:0]  grp_part   = '0;
  logic [STAMP_W-1:0] prev_stamp = '0;
  logic [ABS_W-1:0]   abs_stamp  = '0;
  bit                 any_stored = 1'b0;
  bit                 at_start   = 1'b1;

  // Handshake bookkeeping between the sampling edge and the driving edge.
  bit          word_taken   = 1'b0;
  bit          result_taken = 1'b0;
  bit          push_quiet   = 1'b0;
  bit          pop_quiet    = 1'b0;
  int unsigned push_wait    = 0;
  int unsigned pop_wait     = 0;

  int      mismatches = 0;
  int      kind_tally [6];
  int      groups_closed = 0;
  int      groups_with_hits = 0;
  result_t oldest;

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Slowest correct run is well under half a million ns; allow ten times that.
  initial begin
    #5_000_000;
    $display("tdc_hit_word_decoder_tb: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic logic [WORD_W-1:0] hit_word(input logic hi, input logic [CHAN_W-1:0] ch,
                                                 input logic [VALUE_W-1:0] val);
    return {1'b1, hi, ch, val};
  endfunction

  function void add_word(input logic [WORD_W-1:0] w, input logic last, input logic rst);
    word_item_t item;
    item.word    = w;
    item.last    = last;
    item.restart = rst;
    word_q.push_back(item);
  endfunction

  // Flip between quiet stretches with no gaps and stretches with drawn gaps.
  function automatic int unsigned draw_wait(inout bit quiet);
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 12);
  endfunction

  // Decode one word against the shadow state and return the record it yields.
  function automatic result_t decode_word(input logic [WORD_W-1:0] w, input logic last,
                                          input logic rst);
    result_t             r;
    logic [CHAN_W-1:0]   ch;
    logic [CH_IDX_W-1:0] ci;
    logic [STAMP_W-1:0]  stamp;
    r      = '0;
    r.kind = KIND_IGNORED;
    // A new group starts with empty slots.
    if (at_start) begin
      foreach (slot_count[i]) slot_count[i] = '0;
      any_stored = 1'b0;
      at_start   = 1'b0;
    end
    // Restart clears the stamp parts on any word, but leaves the slots alone.
    if (rst) begin
      roll_part  = '0;
      grp_part   = '0;
      prev_stamp = '0;
      abs_stamp  = '0;
    end
    if (w[31]) begin
      ch        = w[29:24];
      ci        = ch[CH_IDX_W-1:0];
      r.channel = ch;
      r.value   = w[VALUE_W-1:0];
      if (ch < CHANNELS) begin
        if (slot_count[ci] < HITS) begin
          r.slot         = slot_count[ci];
          slot_count[ci] = slot_count[ci] + 1'b1;
          any_stored     = 1'b1;
          r.kind         = KIND_HIT_STORED;
        end else begin
          r.kind = KIND_HIT_DROPPED;
        end
      end else begin
        r.kind = KIND_CHAN_RANGE;
      end
    end else if (w[31:24] == ROLLOVER_TAG) begin
      roll_part = w[PART_W-1:0];
      r.kind    = KIND_ROLLOVER;
    end else if (w[31:28] == GROUP_TAG) begin
      grp_part = w[PART_W-1:0];
      r.kind   = KIND_GROUP;
    end
    // Fold the 48-bit stamp into the absolute one; add a wrap when it went back.
    if (last) begin
      stamp     = {roll_part, grp_part};
      abs_stamp = abs_stamp + {16'h0, stamp} - {16'h0, prev_stamp};
      if (stamp < prev_stamp) abs_stamp = abs_stamp + 64'h0001_0000_0000_0000;
      prev_stamp  = stamp;
      r.done      = 1'b1;
      r.ok        = any_stored;
      r.timestamp = abs_stamp;
      at_start    = 1'b1;
    end
    return r;
  endfunction

  function void check_field(input string name, input logic [63:0] want,
                            input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Word driver: present the head of the word queue, hold it until it
  // transfers, then wait a drawn number of cycles before the next one.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (word_taken) begin
        word_taken = 1'b0;
        word_q.delete(0);
        push_wait = draw_wait(push_quiet);
      end
      if (push_wait != 0) begin
        push_wait--;
        push <= 1'b0;
      end else if (word_q.size() != 0) begin
        push        <= 1'b1;
        data_word_i <= word_q[0].word;
        last_word_i <= word_q[0].last;
        restart_i   <= word_q[0].restart;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result reader: raise pop after a drawn stall per record.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (result_taken) begin
        result_taken = 1'b0;
        pop_wait = draw_wait(pop_quiet);
      end
      if (pop_wait != 0) begin
        pop_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on every word transfer, check on every result transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        decoded_q.push_back(decode_word(data_word_i, last_word_i, restart_i));
        word_taken = 1'b1;
      end
      if (pop && !empty) begin
        result_taken = 1'b1;
        if (decoded_q.size() == 0) begin
          mismatches++;
          $display("%0t: result popped with none expected, kind 0x%0h timestamp 0x%0h",
                   $time, word_kind_o, timestamp_o);
        end else begin
          oldest = decoded_q.pop_front();
          check_field("word_kind", oldest.kind, word_kind_o);
          check_field("channel", oldest.channel, channel_o);
          check_field("hit_slot", oldest.slot, hit_slot_o);
          check_field("hit_value", oldest.value, hit_value_o[VALUE_W-1:0]);
          check_field("group_done", oldest.done, group_done_o);
          check_field("group_ok", oldest.ok, group_ok_o);
          check_field("timestamp", oldest.timestamp, timestamp_o);
          kind_tally[oldest.kind]++;
          if (oldest.done) begin
            groups_closed++;
            if (oldest.ok) groups_with_hits++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    word_item_t         grp_q[$];
    word_item_t         item;
    int                 n;
    int                 r;
    logic [CHAN_W-1:0]  hot;
    logic [PART_W-1:0]  roll_val;
    logic [PART_W-1:0]  grp_val;
    logic [WORD_W-1:0]  w;

    roll_val = '0;
    grp_val  = '0;

    // First group: field extremes, both hit types, range edges, max stamp.
    add_word(hit_word(1'b0, 6'd0, 24'h7FFFFF), 1'b0, 1'b1);
    add_word(hit_word(1'b1, 6'd1, 24'h800000), 1'b0, 1'b0);
    add_word(hit_word(1'b1, CHAN_W'(CHANNELS - 1), 24'hFFFFFF), 1'b0, 1'b0);
    add_word(hit_word(1'b0, CHAN_W'(CHANNELS), 24'h000001), 1'b0, 1'b0);
    add_word(hit_word(1'b1, 6'h3F, 24'h000000), 1'b0, 1'b0);
    add_word({ROLLOVER_TAG, 24'hFFFFFF}, 1'b0, 1'b0);
    add_word({GROUP_TAG, 28'hFFF_FFFF}, 1'b1, 1'b0);
    // Second group: overflow one channel's slots, then let the stamp go back.
    for (int i = 0; i <= HITS; i++) begin
      add_word(hit_word(i[0], 6'd2, VALUE_W'($urandom)), 1'b0, 1'b0);
    end
    add_word({ROLLOVER_TAG, 24'h000000}, 1'b0, 1'b0);
    add_word({GROUP_TAG, 28'h000_0001}, 1'b1, 1'b0);
    // Third group: ignored words, restart mid group, restart on the last word.
    add_word(32'h7FFF_FFFF, 1'b0, 1'b0);
    add_word(32'h2000_0000, 1'b0, 1'b0);
    add_word(32'h11AB_CDEF, 1'b0, 1'b0);
    add_word({GROUP_TAG, 28'h000_0005}, 1'b0, 1'b1);
    add_word({ROLLOVER_TAG, 24'h000002}, 1'b1, 1'b1);

    // Random part: mostly well-formed groups, some raw noise words.
    while (word_q.size() < WORD_TARGET) begin
      grp_q.delete();
      if ($urandom_range(0, 19) == 0) begin
        add_word($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        continue;
      end
      hot = CHAN_W'($urandom_range(0, CHANNELS - 1));
      n   = ($urandom_range(0, 7) == 0) ? $urandom_range(HITS, HITS + 6) : $urandom_range(0, 8);
      // Hits: favor one channel so slots fill up now and then.
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(0, 9);
        if (r < 4) begin
          item.word = hit_word(1'($urandom), hot, VALUE_W'($urandom));
        end else if (r < 9) begin
          item.word = hit_word(1'($urandom), CHAN_W'($urandom_range(0, CHANNELS - 1)),
                               VALUE_W'($urandom));
        end else begin
          item.word = hit_word(1'($urandom), CHAN_W'($urandom_range(CHANNELS, 63)),
                               VALUE_W'($urandom));
        end
        item.last    = 1'b0;
        item.restart = ($urandom_range(0, 39) == 0);
        grp_q.push_back(item);
      end
      // Rollover word, usually one step on, dropped in at a random place.
      if ($urandom_range(0, 3) == 0) begin
        roll_val     = ($urandom_range(0, 7) == 0) ? PART_W'($urandom) : roll_val + 1'b1;
        item.word    = {ROLLOVER_TAG, roll_val};
        item.last    = 1'b0;
        item.restart = 1'b0;
        grp_q.insert($urandom_range(0, grp_q.size()), item);
      end
      // Ignored word: type 01, or type 00 that is neither rollover nor group.
      if ($urandom_range(0, 4) == 0) begin
        w = $urandom;
        if ($urandom_range(0, 1)) begin
          w[31:30] = 2'b01;
        end else begin
          w[31:30] = 2'b00;
          if (w[31:28] == GROUP_TAG) w[28] = 1'b1;
          if (w[31:24] == ROLLOVER_TAG) w[24] = 1'b1;
        end
        item.word    = w;
        item.last    = 1'b0;
        item.restart = 1'b0;
        grp_q.insert($urandom_range(0, grp_q.size()), item);
      end
      // Close the group, normally on a group word that moves the stamp ahead.
      if ($urandom_range(0, 5) != 0) begin
        grp_val         = ($urandom_range(0, 7) == 0)
                          ? PART_W'($urandom)
                          : grp_val + PART_W'($urandom_range(1, 4000));
        w               = $urandom;
        w[31:28]        = GROUP_TAG;
        w[PART_W-1:0]   = grp_val;
        item.word       = w;
      end else begin
        item.word = hit_word(1'($urandom), hot, VALUE_W'($urandom));
      end
      item.last    = 1'b1;
      item.restart = ($urandom_range(0, 39) == 0);
      grp_q.push_back(item);
      if ($urandom_range(0, 9) == 0) grp_q[0].restart = 1'b1;
      foreach (grp_q[i]) word_q.push_back(grp_q[i]);
    end

    // Hold reset, then release it away from the rising edge.
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every word sent, every record popped, then idle before the report.
    wait (word_q.size() == 0);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $write("Decoded %0d words: %0d stored, %0d dropped, ",
           kind_tally.sum(), kind_tally[KIND_HIT_STORED], kind_tally[KIND_HIT_DROPPED]);
    $display("%0d out of range, %0d rollover, %0d group, %0d ignored",
             kind_tally[KIND_CHAN_RANGE], kind_tally[KIND_ROLLOVER], kind_tally[KIND_GROUP],
             kind_tally[KIND_IGNORED]);
    $display("Closed %0d groups, %0d of them with stored hits", groups_closed, groups_with_hits);
    if (mismatches == 0) begin
      $display("tdc_hit_word_decoder_tb: done, clean");
    end else begin
      $display("tdc_hit_word_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/tdc_hwd_pkg.sv
rtl/core/tdc_hwd_front.sv
rtl/core/tdc_hwd_back.sv
rtl/core/tdc_hit_word_decoder.sv
tb/tdc_hit_word_decoder_tb.sv
